// ===== hw/rtl/tlff_pkg.sv =====
// shared types and constants for the two-layer relu feed-forward block
`timescale 1ns / 1ps
package tlff_pkg;
  localparam int ModelDim  = 16;
  localparam int HiddenDim = 64;
  localparam int MdW = $clog2(ModelDim);
  localparam int HdW = $clog2(HiddenDim);
  localparam int AccW = 40;

  typedef enum logic [2:0] {
    ActW1  = 3'd0,
    ActB1  = 3'd1,
    ActW2  = 3'd2,
    ActB2  = 3'd3,
    ActIn  = 3'd4
  } action_e;

  // one multiply-accumulate request to the shared unit
  typedef struct packed {
    logic               clr;
    logic               mac;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] bias;
  } mac_req_t;
endpackage

// ===== hw/rtl/tlff_mac.sv =====
// shared multiply-accumulate unit with registered product
`timescale 1ns / 1ps
module tlff_mac (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tlff_pkg::mac_req_t       req_i,
  output logic signed [tlff_pkg::AccW-1:0] acc_o
);
  import tlff_pkg::*;
  logic signed [31:0] prod_q;
  logic               prod_vld_q;
  logic signed [AccW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
      prod_q     <= '0;
    end else begin
      prod_q     <= req_i.a * req_i.b;
      prod_vld_q <= req_i.mac;
      if (req_i.clr) begin
        acc_q <= {{(AccW-28){req_i.bias[15]}}, req_i.bias, 12'd0};
      end else if (prod_vld_q) begin
        acc_q <= acc_q + {{(AccW-32){prod_q[31]}}, prod_q};
      end
    end
  end
  assign acc_o = acc_q;
endmodule

// ===== hw/rtl/two_layer_relu_feed_forward_top.sv =====
`timescale 1ns / 1ps
// Feed-forward block: loads go into internal memories one per cycle while the block is idle
// with its output register empty; an input item with the final flag starts the computation,
// after which the block holds s_axis_tready low. One shared multiplier-accumulator does all
// work, one product a cycle while accumulating; layer one covers the 64 hidden rows and
// layer two the dim output rows plus any wait for the output register, dim being the
// active model width. Results leave through one output register.
module two_layer_relu_feed_forward_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[2:0], row_index[8:3], col_index[14:9], data_value[30:15]
  input  logic [31:0] s_axis_tdata,
  // final_element
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_index[3:0], out_value[19:4]
  output logic [23:0] m_axis_tdata,
  // out_last
  output logic        m_axis_tlast,
  // saturated
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  import tlff_pkg::*;

  typedef enum logic [2:0] {
    Idle, L1Clr, L1Mac, L1Done, L2Clr, L2Mac, L2Done, Emit
  } state_e;

  logic [2:0]  act;
  logic [5:0]  row, col;
  logic signed [15:0] val;
  assign act = s_axis_tdata[2:0];
  assign row = s_axis_tdata[8:3];
  assign col = s_axis_tdata[14:9];
  assign val = s_axis_tdata[30:15];

  logic signed [15:0] w1_mem [HiddenDim*ModelDim];
  logic signed [15:0] w2_mem [ModelDim*HiddenDim];
  logic signed [15:0] hid_mem [HiddenDim];
  logic signed [15:0] x_q [ModelDim];
  logic signed [15:0] b1_mem [HiddenDim];
  logic [HiddenDim-1:0] b1_vld_q;
  logic signed [15:0] b2_q [ModelDim];
  logic signed [15:0] w1_rd_q, w2_rd_q, hid_rd_q, b1_rd_q;

  state_e      state_q;
  logic [4:0]  dim_q;
  logic [HdW-1:0] i_q;
  logic [HdW:0]   j_q;
  logic        hclip_q;
  logic        ovld_q, olast_q, osat_q;
  logic [3:0]  oidx_q;
  logic signed [15:0] oval_q;
  logic        pend_q;
  logic        clr_q;

  logic in_acc;
  assign s_axis_tready = (state_q == Idle) && !ovld_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // memory writes and registered reads
  logic [HdW-1:0] rd_j;
  assign rd_j = j_q[HdW-1:0];
  always_ff @(posedge clk_i) begin
    if (in_acc && act == ActW1 && col < 6'(ModelDim))
      w1_mem[{row[HdW-1:0], col[MdW-1:0]}] <= val;
    if (in_acc && act == ActW2 && row < 6'(ModelDim))
      w2_mem[{row[MdW-1:0], col[HdW-1:0]}] <= val;
    if (in_acc && act == ActB1) b1_mem[row[HdW-1:0]] <= val;
    w1_rd_q  <= w1_mem[{i_q, rd_j[MdW-1:0]}];
    w2_rd_q  <= w2_mem[{i_q[MdW-1:0], rd_j}];
    hid_rd_q <= hid_mem[rd_j];
    // a first-layer bias never written reads as zero
    b1_rd_q  <= b1_vld_q[i_q] ? b1_mem[i_q] : 16'sd0;
  end

  logic signed [15:0] x_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= '0;
      for (int k = 0; k < ModelDim; k++) b2_q[k] <= '0;
    end else if (in_acc) begin
      if (act == ActB1) b1_vld_q[row[HdW-1:0]] <= 1'b1;
      if (act == ActB2 && row < 6'(ModelDim)) b2_q[row[MdW-1:0]] <= val;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_acc && act == ActIn && col < 6'(ModelDim)) x_q[col[MdW-1:0]] <= val;
    x_rd_q <= x_q[rd_j[MdW-1:0]];
  end

  // shared unit: operands come from registered reads at the index, and the product is registered again
  mac_req_t req;
  logic signed [AccW-1:0] acc;
  logic mac_vld_q;
  always_comb begin
    // bias lands in the cycle after the clear state, once its registered read is ready
    req.clr  = clr_q;
    req.mac  = mac_vld_q;
    req.a    = (state_q == L1Mac || state_q == L1Done) ? x_rd_q : hid_rd_q;
    req.b    = (state_q == L1Mac || state_q == L1Done) ? w1_rd_q : w2_rd_q;
    req.bias = (state_q == L1Mac) ? b1_rd_q : b2_q[i_q[MdW-1:0]];
  end
  tlff_mac u_mac (.clk_i, .rst_ni, .req_i(req), .acc_o(acc));

  // rounding: floor((acc + 2048) / 4096)
  logic signed [AccW-1:0] rsum;
  logic signed [AccW-13:0] rnd;
  assign rsum = acc + AccW'(2048);
  assign rnd  = rsum[AccW-1:12];
  logic h_pos, h_ovf, y_hi, y_lo;
  assign h_pos = !rnd[AccW-13];
  assign h_ovf = h_pos && (rnd > (AccW-12)'(32767));
  assign y_hi  = rnd > (AccW-12)'(32767);
  assign y_lo  = rnd < -(AccW-12)'(32768);

  logic [HdW:0] jmax;
  assign jmax = (state_q == L1Mac) ? (HdW+1)'(dim_q) : (HdW+1)'(HiddenDim);

  logic hid_we;
  assign hid_we = (state_q == L1Done) && !pend_q && !mac_vld_q;
  always_ff @(posedge clk_i) begin
    if (hid_we) hid_mem[i_q] <= !h_pos ? 16'sd0 : (h_ovf ? 16'sd32767 : rnd[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      dim_q     <= 5'(ModelDim);
      i_q       <= '0;
      j_q       <= '0;
      hclip_q   <= 1'b0;
      ovld_q    <= 1'b0;
      olast_q   <= 1'b0;
      osat_q    <= 1'b0;
      oidx_q    <= '0;
      oval_q    <= '0;
      mac_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      clr_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == 5'd0) dim_q <= 5'd1;
        else if (cfg_wdata_i > 5'(ModelDim)) dim_q <= 5'(ModelDim);
        else dim_q <= cfg_wdata_i;
      end
      if (ovld_q && m_axis_tready) ovld_q <= 1'b0;
      mac_vld_q <= ((state_q == L1Mac) || (state_q == L2Mac)) && (j_q < jmax);
      clr_q     <= (state_q == L1Clr) || (state_q == L2Clr);
      case (state_q)
        Idle: begin
          if (in_acc && act == ActIn && s_axis_tlast) begin
            state_q <= L1Clr;
            i_q     <= '0;
            hclip_q <= 1'b0;
          end
        end
        L1Clr, L2Clr: begin
          j_q     <= '0;
          state_q <= (state_q == L1Clr) ? L1Mac : L2Mac;
        end
        L1Mac, L2Mac: begin
          if (j_q < jmax) j_q <= j_q + 1'b1;
          else begin
            state_q <= (state_q == L1Mac) ? L1Done : L2Done;
            pend_q  <= 1'b1;
          end
        end
        L1Done: begin
          // wait for the last product to land
          if (pend_q) pend_q <= 1'b0;
          else if (!mac_vld_q) begin
            if (h_ovf) hclip_q <= 1'b1;
            if (i_q == HdW'(HiddenDim - 1)) begin
              i_q <= '0;
              state_q <= L2Clr;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= L1Clr;
            end
          end
        end
        L2Done: begin
          if (pend_q) pend_q <= 1'b0;
          else if (!mac_vld_q) state_q <= Emit;
        end
        Emit: begin
          if (!ovld_q) begin
            ovld_q  <= 1'b1;
            oidx_q  <= i_q[3:0];
            oval_q  <= y_hi ? 16'sd32767 : (y_lo ? -16'sd32768 : rnd[15:0]);
            osat_q  <= hclip_q || y_hi || y_lo;
            olast_q <= (5'(i_q) + 5'd1 == dim_q);
            if (5'(i_q) + 5'd1 == dim_q) state_q <= Idle;
            else begin
              i_q <= i_q + 1'b1;
              state_q <= L2Clr;
            end
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {4'd0, oval_q, oidx_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = osat_q;

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != Idle) |-> !s_axis_tready) else $error("ready while busy");
  a_emit_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Emit && !ovld_q) |=> ovld_q) else $error("emit without result");
  a_idx_in_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> (5'(oidx_q) < dim_q)) else $error("output index past width");
endmodule

// ===== tb/two_layer_relu_feed_forward_top_tb.sv =====
`timescale 1ns / 1ps
// testbench for the two-layer relu feed-forward block: config, directed, random and backpressure tests
module two_layer_relu_feed_forward_top_tb;
  import tlff_pkg::*;

  localparam logic [2:0] ActSpare = 3'd5;  // first of the unused actions 5..7
  localparam int CycleLimit = 3000000;

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        last;
    logic        sat;
  } out_elem_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;

  two_layer_relu_feed_forward_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_we_i, .cfg_wdata_i
  );

  // mirror of the block's memories
  logic signed [15:0] w1_mem [HiddenDim][ModelDim];
  logic signed [15:0] b1_mem [HiddenDim];
  logic signed [15:0] w2_mem [ModelDim][HiddenDim];
  logic signed [15:0] b2_mem [ModelDim];
  logic signed [15:0] x_vec  [ModelDim];
  bit                 w1_ok  [HiddenDim][ModelDim];
  bit                 w2_ok  [ModelDim][HiddenDim];
  bit                 x_ok   [ModelDim];
  int                 dim_q;

  out_elem_t expected_outputs[$];
  int        fail_count;
  int        items_sent;
  int        vectors_done;
  int        outputs_seen;
  int        sat_seen;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        hold_request;
  int        stall_left;
  longint    cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("two_layer_relu_feed_forward_top verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch at output %0d: %s got %0h expected %0h", outputs_seen, what, got, exp_v);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_elem_t e;
      if (expected_outputs.size() == 0) begin
        report("unexpected output", m_axis_tdata, 0);
      end else begin
        e = expected_outputs.pop_front();
        if (m_axis_tdata[3:0] !== e.idx) report("out_index", m_axis_tdata[3:0], e.idx);
        if (m_axis_tdata[19:4] !== e.val) report("out_value", m_axis_tdata[19:4], e.val);
        if (m_axis_tdata[23:20] !== 4'd0) report("pad bits", m_axis_tdata[23:20], 0);
        if (m_axis_tlast !== e.last) report("out_last", m_axis_tlast, e.last);
        if (m_axis_tuser !== e.sat) report("saturated", m_axis_tuser, e.sat);
        if (e.sat) sat_seen++;
      end
      outputs_seen++;
    end
  end

  function automatic longint round_q412(input longint acc);
    return (acc + 2048) >>> 12;
  endfunction

  // runs both layers over the mirrored memories and queues the outputs
  task automatic predict_vector();
    logic signed [15:0] hid [HiddenDim];
    bit     hid_clip;
    longint acc;
    longint h;
    out_elem_t e;
    hid_clip = 0;
    for (int i = 0; i < HiddenDim; i++) begin
      acc = longint'(b1_mem[i]) * 4096;
      for (int j = 0; j < dim_q; j++) acc += longint'(x_vec[j]) * longint'(w1_mem[i][j]);
      h = round_q412(acc);
      if (h < 0) h = 0;
      if (h > 32767) begin
        h = 32767;
        hid_clip = 1;
      end
      hid[i] = h[15:0];
    end
    for (int i = 0; i < dim_q; i++) begin
      acc = longint'(b2_mem[i]) * 4096;
      for (int j = 0; j < HiddenDim; j++) acc += longint'(hid[j]) * longint'(w2_mem[i][j]);
      h = round_q412(acc);
      e.sat = hid_clip;
      if (h > 32767) begin
        h = 32767;
        e.sat = 1;
      end else if (h < -32768) begin
        h = -32768;
        e.sat = 1;
      end
      e.idx = i[3:0];
      e.val = h[15:0];
      e.last = (i + 1 == dim_q);
      expected_outputs.push_back(e);
    end
    vectors_done++;
  endtask

  task automatic apply_request(input logic [2:0] act, input int row, input int col,
                               input logic [15:0] val, input bit fin);
    case (act)
      ActW1: if (row < HiddenDim && col < ModelDim) begin
        w1_mem[row][col] = val;
        w1_ok[row][col] = 1;
      end
      ActB1: if (row < HiddenDim) b1_mem[row] = val;
      ActW2: if (row < ModelDim && col < HiddenDim) begin
        w2_mem[row][col] = val;
        w2_ok[row][col] = 1;
      end
      ActB2: if (row < ModelDim) b2_mem[row] = val;
      ActIn: begin
        if (col < ModelDim) begin
          x_vec[col] = val;
          x_ok[col] = 1;
        end
        if (fin) predict_vector();
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [2:0] act, input int row, input int col,
                              input logic [15:0] val, input bit fin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, val, col[5:0], row[5:0], act};
    s_axis_tlast  <= fin;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_request(act, row, col, val, fin);
    items_sent++;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 4095)) - 16'd2048;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // loads every weight and input entry that the next vector reads and that was never written
  task automatic fill_missing();
    for (int i = 0; i < HiddenDim; i++)
      for (int j = 0; j < dim_q; j++)
        if (!w1_ok[i][j]) send_request(ActW1, i, j, rand_value(), 0);
    for (int i = 0; i < dim_q; i++)
      for (int j = 0; j < HiddenDim; j++)
        if (!w2_ok[i][j]) send_request(ActW2, i, j, rand_value(), 0);
    for (int j = 0; j < dim_q; j++)
      if (!x_ok[j]) send_request(ActIn, 0, j, rand_value(), 0);
  endtask

  task automatic send_final(input int col);
    fill_missing();
    send_request(ActIn, $urandom_range(63), col, rand_value(), 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_dim(input logic [4:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    dim_q = (v == 0) ? 1 : (v > ModelDim) ? ModelDim : v;
  endtask

  // register extremes, each followed by a vector at that width
  task automatic test_config_extremes();
    write_dim(5'd0);
    send_final($urandom_range(15));
    write_dim(5'd31);
    send_final(ModelDim - 1);
    write_dim(5'd17);
    send_final(0);
    write_dim(5'd1);
    send_final(0);
  endtask

  // field extremes, ignored requests and the out-of-range cases
  task automatic test_directed();
    write_dim(5'd2);
    send_request(ActB1, HiddenDim - 1, 63, 16'h7fff, 0);
    send_request(ActB1, 0, 0, 16'h8000, 0);
    send_request(ActB2, ModelDim - 1, 0, 16'h7fff, 0);
    send_request(ActB2, ModelDim, 0, 16'h1234, 0);
    send_request(ActB2, 63, 63, 16'hffff, 0);
    send_request(ActW1, 5, ModelDim, 16'h7fff, 0);
    send_request(ActW1, 0, 63, 16'h8000, 0);
    send_request(ActW2, ModelDim, 0, 16'h7fff, 0);
    send_request(ActW2, 1, 63, 16'h8000, 0);
    send_request(ActW2, 63, 0, 16'h0001, 0);
    send_request(ActSpare, 7, 9, 16'h5555, 1);
    send_request(ActSpare + 3'd1, 63, 63, 16'hffff, 0);
    send_request(ActSpare + 3'd2, 0, 0, 16'haaaa, 1);
    send_request(ActIn, 0, 0, 16'h7fff, 0);
    send_request(ActIn, 0, 1, 16'h8000, 0);
    send_final(63);
    send_request(ActIn, 0, 0, 16'h0000, 0);
    send_request(ActIn, 0, 1, 16'h0000, 0);
    send_final(ModelDim);
    send_request(ActB1, 63, 0, 16'h0000, 0);
    send_request(ActB1, 0, 0, 16'h0000, 0);
    send_request(ActIn, 0, 0, 16'h0800, 0);
    send_final(1);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 20) send_request(ActIn, $urandom_range(63), $urandom_range(ModelDim - 1),
                             rand_value(), 0);
    else if (r < 32) send_request(ActW1, $urandom_range(HiddenDim - 1),
                                  $urandom_range(ModelDim - 1), rand_value(), 0);
    else if (r < 44) send_request(ActW2, $urandom_range(ModelDim - 1),
                                  $urandom_range(HiddenDim - 1), rand_value(), 0);
    else if (r < 60) send_request(ActB1, $urandom_range(HiddenDim - 1), $urandom_range(63),
                                  rand_value(), 0);
    else if (r < 72) send_request(ActB2, $urandom_range(ModelDim - 1), $urandom_range(63),
                                  rand_value(), 0);
    else if (r < 84) send_final($urandom_range(0, 9) == 0 ? $urandom_range(63)
                                                          : $urandom_range(ModelDim - 1));
    else if (r < 94) send_request(3'($urandom_range(ActB2)), $urandom_range(63),
                                  $urandom_range(63), rand_value(), $urandom_range(1));
    else send_request(ActSpare + 3'($urandom_range(2)), $urandom_range(63),
                      $urandom_range(63), 16'($urandom), $urandom_range(1));
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int n);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 39) write_dim(($urandom_range(0, 7) == 0) ? 5'($urandom)
                                                                : 5'($urandom_range(0, 4)));
      random_request();
    end
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_dim(5'd16);
    fill_missing();
    hold_request = 3000;
    send_final(3);
    send_final(7);
    for (int k = 0; k < 20; k++) random_request();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cycle_count = 0;
    fail_count = 0;
    items_sent = 0;
    vectors_done = 0;
    outputs_seen = 0;
    sat_seen = 0;
    hold_request = 0;
    stall_left = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    dim_q = ModelDim;
    for (int i = 0; i < HiddenDim; i++) begin
      b1_mem[i] = 0;
      for (int j = 0; j < ModelDim; j++) begin
        w1_mem[i][j] = 0;
        w2_mem[j][i] = 0;
        w1_ok[i][j] = 0;
        w2_ok[j][i] = 0;
      end
    end
    for (int j = 0; j < ModelDim; j++) begin
      b2_mem[j] = 0;
      x_vec[j] = 0;
      x_ok[j] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_config_extremes();
    test_directed();
    test_random(23, 87, 160);
    test_random(87, 23, 160);
    test_random(0, 0, 160);
    test_backpressure();

    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("sent %0d requests, %0d vectors computed, %0d outputs checked",
             items_sent, vectors_done, outputs_seen);
    $display("%0d saturated outputs, widths 1..16, long receiver hold included", sat_seen);
    if (fail_count == 0 && expected_outputs.size() == 0) begin
      $display("two_layer_relu_feed_forward_top verification clean");
    end else begin
      $display("%0d mismatches, %0d outputs missing", fail_count, expected_outputs.size());
      $display("two_layer_relu_feed_forward_top verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/tlff_pkg.sv
hw/rtl/tlff_mac.sv
hw/rtl/two_layer_relu_feed_forward_top.sv
tb/two_layer_relu_feed_forward_top_tb.sv
